// ===== design/i2c_slave_buffer_fsm_macros.svh =====
// Assertion macros for the I2C slave buffer block.
// Included by the top level; needs no package and no other header.
`ifndef I2C_SLAVE_BUFFER_FSM_MACROS_SVH
`define I2C_SLAVE_BUFFER_FSM_MACROS_SVH

`ifndef ASSERT_OFF

// Check that a condition implies another one in the same cycle.
`define I2CSB_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another one in the next cycle.
`define I2CSB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define I2CSB_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define I2CSB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== design/i2csb_pkg.sv =====
// Shared types and constants of the I2C slave buffer block.
// Used by every module of the block; depends on nothing.
package i2csb_pkg;

    // Default buffer depth and fixed field widths
    localparam int BUFFER_DEPTH_DEF = 64;
    localparam int LEN_W            = 7;
    localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

    // Configuration port
    localparam int   APB_AW            = 3;
    localparam int   APB_DW            = 32;
    localparam logic CFG_BUFFER_LENGTH = 1'b0;

    // Request opcodes
    localparam logic [1:0] OP_EVENT   = 2'd0;
    localparam logic [1:0] OP_HOST_WR = 2'd1;
    localparam logic [1:0] OP_HOST_RD = 2'd2;

    // Peripheral status codes (status2 << 16 | status1)
    localparam logic [23:0] EV_ADDR_WRITE = 24'h020002;
    localparam logic [23:0] EV_ADDR_READ  = 24'h060082;
    localparam logic [23:0] EV_RX_BYTE    = 24'h020040;
    localparam logic [23:0] EV_STOP       = 24'h000010;
    localparam logic [23:0] EV_SENDABLE   = 24'h060080;
    localparam logic [23:0] EV_ACK_FAIL   = 24'h000400;

    localparam logic [7:0] TX_STATUS = 8'h00;
    localparam logic [7:0] TX_PAD    = 8'hff;

    typedef enum logic [2:0] {
        PH_WAIT_MASTER = 3'd0,
        PH_WAIT_CMD    = 3'd1,
        PH_GOT_CMD     = 3'd2,
        PH_RX_DATA     = 3'd3,
        PH_WAIT_SEND   = 3'd4,
        PH_SENT_STATUS = 3'd5,
        PH_TX_DATA     = 3'd6
    } t_phase;

    // Request class as decided by the front end
    typedef enum logic [3:0] {
        K_NOP,
        K_HOST_WR,
        K_HOST_RD,
        K_EV_NONE,
        K_ADDR_WR,
        K_ADDR_RD,
        K_RX,
        K_STOP,
        K_SEND,
        K_ACK_FAIL
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic       berr;
        logic [7:0] data;
        logic [5:0] addr;
    } t_req;

endpackage

// ===== design/i2csb_if.sv =====
// Valid/ready channel interfaces of the I2C slave buffer block.
// Request channel in, result channel out; no package needed.
interface i2csb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [23:0] status_word;
    logic        bus_error;
    logic [7:0]  rx_byte;
    logic [5:0]  host_addr;
    logic [7:0]  host_data;

    modport source (
        output valid, op, status_word, bus_error, rx_byte, host_addr, host_data,
        input  ready
    );
    modport sink (
        input  valid, op, status_word, bus_error, rx_byte, host_addr, host_data,
        output ready
    );
endinterface

interface i2csb_out_if;
    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       command_done;
    logic [7:0] command_byte;
    logic [7:0] read_data;
    logic [2:0] phase;

    modport source (
        output valid, tx_valid, tx_byte, command_done, command_byte, read_data, phase,
        input  ready
    );
    modport sink (
        input  valid, tx_valid, tx_byte, command_done, command_byte, read_data, phase,
        output ready
    );
endinterface

// ===== design/i2c_slave_buffer_fsm.sv =====
// Top level of the I2C slave buffer block: config register and assembly.
// Depends on i2csb_pkg, i2csb_if, i2csb_front, i2csb_queue, i2csb_back, macros header.
//
//   Channel   Dir   Handshake              Carries
//   i_in      in    valid/ready            op, status_word, bus_error, rx_byte,
//                                          host_addr, host_data
//   o_out     out   valid/ready            tx_valid, tx_byte, command_done,
//                                          command_byte, read_data, phase
//   APB       in    psel/penable/pready    buffer_length at offset 0
//
// One request a cycle sustained while o_out is not stalled; a taken request is
// first registered in the queue, then the phase machine and memory port load
// the result register, where the result waits until o_out takes it.
// The single-port buffer memory and the phase register set the rate.
// Reset clears control state and marks every buffer byte invalid (reads 0).
// A stalled output holds the back end; the two-entry queue then fills and
// drops i_in.ready.
`include "i2c_slave_buffer_fsm_macros.svh"

module i2c_slave_buffer_fsm #(
    parameter int BUFFER_DEPTH = i2csb_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    i2csb_in_if.sink                      i_in,
    i2csb_out_if.source                   o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [i2csb_pkg::APB_AW-1:0]  paddr,
    input  logic [i2csb_pkg::APB_DW-1:0]  pwdata,
    output logic [i2csb_pkg::APB_DW-1:0]  prdata,
    output logic                          pready
);

    localparam int LW = i2csb_pkg::LEN_W;

    logic [LW-1:0]   r_buffer_length;
    logic            w_cfg_wr;
    logic            w_cfg_hit;

    logic            w_push;
    logic            w_q_ready;
    i2csb_pkg::t_req w_front_req;
    logic            w_q_valid;
    i2csb_pkg::t_req w_q_req;
    logic            w_pop;

    // Config port: zero-wait APB, one register
    assign pready    = 1'b1;
    assign w_cfg_hit = (paddr[2] == i2csb_pkg::CFG_BUFFER_LENGTH);
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign prdata    = w_cfg_hit ? {{(i2csb_pkg::APB_DW - LW){1'b0}}, r_buffer_length} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_length <= i2csb_pkg::LEN_RESET;
        end else if (w_cfg_wr && w_cfg_hit) begin
            r_buffer_length <= pwdata[LW-1:0];
        end
    end

    // Classify requests
    i2csb_front u_front (
        .i_in      (i_in),
        .i_q_ready (w_q_ready),
        .o_push    (w_push),
        .o_req     (w_front_req)
    );

    // Decouple front and back
    i2csb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_req   (w_front_req),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_req   (w_q_req)
    );

    // Run the protocol and buffer
    i2csb_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (w_q_valid),
        .i_req           (w_q_req),
        .o_pop           (w_pop),
        .i_buffer_length (r_buffer_length),
        .o_out           (o_out)
    );

    // A finished write always lands in the wait phase and sends nothing
    `I2CSB_ASSERT_IMPLY(a_done_idle, i_clk, i_rst_n, o_out.valid && o_out.command_done, o_out.phase == i2csb_pkg::PH_WAIT_MASTER && !o_out.tx_valid, "command_done outside wait phase")
    // A loaded byte only comes from a read transfer
    `I2CSB_ASSERT_IMPLY(a_tx_phase, i_clk, i_rst_n, o_out.valid && o_out.tx_valid, o_out.phase == i2csb_pkg::PH_SENT_STATUS || o_out.phase == i2csb_pkg::PH_TX_DATA, "tx byte outside read phases")
    // Hold the back end while the result waits
    `I2CSB_ASSERT_IMPLY(a_hold_stall, i_clk, i_rst_n, o_out.valid && !o_out.ready, !w_pop, "queue popped while result stalled")
    // Every popped request yields a result next cycle
    `I2CSB_ASSERT_NEXT(a_pop_result, i_clk, i_rst_n, w_pop, o_out.valid, "popped request left no result")

endmodule

// ===== design/i2csb_front.sv =====
// Front end: take a request and classify it into a compact command.
// Depends on i2csb_pkg and i2csb_in_if.
module i2csb_front (
    i2csb_in_if.sink          i_in,
    input  logic              i_q_ready,
    output logic              o_push,
    output i2csb_pkg::t_req   o_req
);

    i2csb_pkg::t_kind w_ev_kind;

    assign i_in.ready = i_q_ready;
    assign o_push     = i_in.valid && i_q_ready;

    // Exact match of the status word
    always_comb begin
        unique case (i_in.status_word)
            i2csb_pkg::EV_ADDR_WRITE: w_ev_kind = i2csb_pkg::K_ADDR_WR;
            i2csb_pkg::EV_ADDR_READ:  w_ev_kind = i2csb_pkg::K_ADDR_RD;
            i2csb_pkg::EV_RX_BYTE:    w_ev_kind = i2csb_pkg::K_RX;
            i2csb_pkg::EV_STOP:       w_ev_kind = i2csb_pkg::K_STOP;
            i2csb_pkg::EV_SENDABLE:   w_ev_kind = i2csb_pkg::K_SEND;
            i2csb_pkg::EV_ACK_FAIL:   w_ev_kind = i2csb_pkg::K_ACK_FAIL;
            default:                  w_ev_kind = i2csb_pkg::K_EV_NONE;
        endcase
    end

    always_comb begin
        o_req.addr = i_in.host_addr;
        o_req.data = i_in.rx_byte;
        o_req.berr = 1'b0;
        unique case (i_in.op)
            i2csb_pkg::OP_EVENT: begin
                o_req.kind = w_ev_kind;
                o_req.berr = i_in.bus_error;
            end
            i2csb_pkg::OP_HOST_WR: begin
                o_req.kind = i2csb_pkg::K_HOST_WR;
                o_req.data = i_in.host_data;
            end
            i2csb_pkg::OP_HOST_RD: o_req.kind = i2csb_pkg::K_HOST_RD;
            default:               o_req.kind = i2csb_pkg::K_NOP;
        endcase
    end

endmodule

// ===== design/i2csb_queue.sv =====
// Two-entry command queue between the front and back ends.
// Depends on i2csb_pkg for the command type.
module i2csb_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  i2csb_pkg::t_req i_req,
    output logic            o_ready,
    input  logic            i_pop,
    output logic            o_valid,
    output i2csb_pkg::t_req o_req
);

    i2csb_pkg::t_req r_slot [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic [1:0]      n_cnt;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_req   = r_slot[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_req;
        end
    end

endmodule

// ===== design/i2csb_back.sv =====
// Back end: phase machine, pointers, buffer memory and result register.
// Depends on i2csb_pkg and i2csb_out_if.
module i2csb_back #(
    parameter int BUFFER_DEPTH = i2csb_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  i2csb_pkg::t_req               i_req,
    output logic                          o_pop,
    input  logic [i2csb_pkg::LEN_W-1:0]   i_buffer_length,
    i2csb_out_if.source                   o_out
);

    localparam int LW = i2csb_pkg::LEN_W;
    localparam int IW = $clog2(BUFFER_DEPTH + 1);
    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam logic [LW-1:0] LEFT_RESET =
        (BUFFER_DEPTH < int'(i2csb_pkg::LEN_RESET)) ? LW'(BUFFER_DEPTH) : i2csb_pkg::LEN_RESET;

    // Protocol state
    i2csb_pkg::t_phase r_phase, n_phase, w_base;
    logic [7:0]        r_cmd, n_cmd;
    logic [IW-1:0]     r_idx, n_idx;
    logic [LW-1:0]     r_left, n_left;
    logic              w_enter;

    // Buffer memory
    logic [7:0]              r_mem [BUFFER_DEPTH];
    logic [BUFFER_DEPTH-1:0] r_valid;
    logic [7:0]              r_mem_q;
    logic                    w_we, w_re;
    logic [AW-1:0]           w_wa, w_ra;

    // Result register
    logic       r_out_valid;
    logic       r_tx_valid, n_tx_valid;
    logic       r_tx_mem, n_tx_mem;
    logic [7:0] r_tx_const, n_tx_const;
    logic       r_done, n_done;
    logic [7:0] r_cmd_out, n_cmd_out;
    logic       r_rd_mem, n_rd_mem;
    logic [2:0] r_out_phase;

    logic          w_adv;
    logic          w_can;
    logic          w_host_ok;
    logic [LW-1:0] w_active;

    assign w_adv     = i_req_valid && (!r_out_valid || o_out.ready);
    assign o_pop     = w_adv;
    assign w_base    = i_req.berr ? i2csb_pkg::PH_WAIT_MASTER : r_phase;
    assign w_can     = (r_left != '0) && (int'(r_idx) < BUFFER_DEPTH);
    assign w_host_ok = (int'(i_req.addr) < BUFFER_DEPTH);

    always_comb begin
        if (int'(i_buffer_length) < BUFFER_DEPTH) begin
            w_active = i_buffer_length;
        end else begin
            w_active = LW'(BUFFER_DEPTH);
        end
    end

    // Next phase
    always_comb begin
        n_phase = r_phase;
        w_enter = 1'b0;
        unique case (i_req.kind) inside
            i2csb_pkg::K_ADDR_WR: begin
                if (w_base == i2csb_pkg::PH_WAIT_MASTER) n_phase = i2csb_pkg::PH_WAIT_CMD;
                else w_enter = 1'b1;
            end
            i2csb_pkg::K_ADDR_RD: begin
                if (w_base == i2csb_pkg::PH_WAIT_MASTER) n_phase = i2csb_pkg::PH_WAIT_SEND;
                else w_enter = 1'b1;
            end
            i2csb_pkg::K_RX: begin
                if (w_base == i2csb_pkg::PH_WAIT_CMD) begin
                    n_phase = i2csb_pkg::PH_GOT_CMD;
                end else if (w_base == i2csb_pkg::PH_GOT_CMD ||
                             w_base == i2csb_pkg::PH_RX_DATA) begin
                    n_phase = i2csb_pkg::PH_RX_DATA;
                end else begin
                    w_enter = 1'b1;
                end
            end
            i2csb_pkg::K_SEND: begin
                if (w_base == i2csb_pkg::PH_WAIT_SEND) begin
                    n_phase = i2csb_pkg::PH_SENT_STATUS;
                end else if (w_base == i2csb_pkg::PH_SENT_STATUS ||
                             w_base == i2csb_pkg::PH_TX_DATA) begin
                    n_phase = i2csb_pkg::PH_TX_DATA;
                end else begin
                    w_enter = 1'b1;
                end
            end
            i2csb_pkg::K_STOP, i2csb_pkg::K_ACK_FAIL: w_enter = 1'b1;
            i2csb_pkg::K_EV_NONE: n_phase = w_base;
            default: n_phase = r_phase;
        endcase
        if (w_enter) begin
            n_phase = i2csb_pkg::PH_WAIT_MASTER;
        end
    end

    // Pointers, memory access and result
    always_comb begin
        n_cmd      = r_cmd;
        n_idx      = r_idx;
        n_left     = r_left;
        w_we       = 1'b0;
        w_wa       = AW'(i_req.addr);
        w_re       = 1'b0;
        w_ra       = AW'(i_req.addr);
        n_tx_valid = 1'b0;
        n_tx_mem   = 1'b0;
        n_tx_const = 8'h00;
        n_done     = 1'b0;
        n_cmd_out  = 8'h00;
        n_rd_mem   = 1'b0;
        case (i_req.kind)
            i2csb_pkg::K_HOST_WR: w_we = w_host_ok;
            i2csb_pkg::K_HOST_RD: begin
                w_re     = w_host_ok;
                n_rd_mem = w_host_ok;
            end
            i2csb_pkg::K_RX: begin
                if (w_base == i2csb_pkg::PH_WAIT_CMD) begin
                    n_cmd = i_req.data;
                end else if ((w_base == i2csb_pkg::PH_GOT_CMD ||
                              w_base == i2csb_pkg::PH_RX_DATA) && w_can) begin
                    w_we   = 1'b1;
                    w_wa   = r_idx[AW-1:0];
                    n_idx  = r_idx + IW'(1);
                    n_left = r_left - LW'(1);
                end
            end
            i2csb_pkg::K_STOP: begin
                if (w_base == i2csb_pkg::PH_GOT_CMD || w_base == i2csb_pkg::PH_RX_DATA) begin
                    n_done    = 1'b1;
                    n_cmd_out = r_cmd;
                end
            end
            i2csb_pkg::K_SEND: begin
                if (w_base == i2csb_pkg::PH_WAIT_SEND) begin
                    n_tx_valid = 1'b1;
                    n_tx_const = i2csb_pkg::TX_STATUS;
                end else if (w_base == i2csb_pkg::PH_SENT_STATUS ||
                             w_base == i2csb_pkg::PH_TX_DATA) begin
                    n_tx_valid = 1'b1;
                    if (w_can) begin
                        w_re     = 1'b1;
                        w_ra     = r_idx[AW-1:0];
                        n_tx_mem = 1'b1;
                        n_idx    = r_idx + IW'(1);
                        n_left   = r_left - LW'(1);
                    end else begin
                        n_tx_const = i2csb_pkg::TX_PAD;
                    end
                end
            end
            default: ;
        endcase
        if (w_enter) begin
            n_cmd  = 8'h00;
            n_idx  = '0;
            n_left = w_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= i2csb_pkg::PH_WAIT_MASTER;
            r_cmd       <= 8'h00;
            r_idx       <= '0;
            r_left      <= LEFT_RESET;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_phase     <= n_phase;
                r_cmd       <= n_cmd;
                r_idx       <= n_idx;
                r_left      <= n_left;
                r_out_valid <= 1'b1;
                if (w_we) begin
                    r_valid[w_wa] <= 1'b1;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Memory: at most one write or one registered read per request
    always_ff @(posedge i_clk) begin
        if (w_adv && w_we) begin
            r_mem[w_wa] <= i_req.data;
        end
        if (w_adv && w_re) begin
            r_mem_q <= r_valid[w_ra] ? r_mem[w_ra] : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_tx_valid  <= n_tx_valid;
            r_tx_mem    <= n_tx_mem;
            r_tx_const  <= n_tx_const;
            r_done      <= n_done;
            r_cmd_out   <= n_cmd_out;
            r_rd_mem    <= n_rd_mem;
            r_out_phase <= n_phase;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.tx_valid     = r_tx_valid;
    assign o_out.tx_byte      = r_tx_mem ? r_mem_q : r_tx_const;
    assign o_out.command_done = r_done;
    assign o_out.command_byte = r_cmd_out;
    assign o_out.read_data    = r_rd_mem ? r_mem_q : 8'h00;
    assign o_out.phase        = r_out_phase;

endmodule
